// ===== design/fap_pkg.sv =====
// fap_pkg: shared constants, codes and controller/datapath link types
// for the fragment admission policer; depends on nothing
package fap_pkg;

  localparam int DefSenders      = 16;
  localparam int FragBytes       = 1024;
  localparam int FragShift       = 10;
  localparam int MaxMsgBytes     = 65536;
  localparam int HeaderBytes     = 16;
  localparam int MsgW            = 19;

  localparam logic [31:0] FrameMagic   = 32'h3143_5745;
  localparam logic [7:0]  FrameVersion = 8'd1;
  localparam logic [10:0] QuartersPerPacket = 11'd4;

  // register indexes
  localparam logic [2:0] RegByteRefill  = 3'd0;
  localparam logic [2:0] RegByteBurst   = 3'd1;
  localparam logic [2:0] RegPktBurst    = 3'd2;
  localparam logic [2:0] RegIdleTimeout = 3'd3;
  localparam logic [2:0] RegElapsedClamp = 3'd4;

  // verdict codes
  localparam logic [2:0] VerdictAccept       = 3'd0;
  localparam logic [2:0] VerdictMalformed    = 3'd1;
  localparam logic [2:0] VerdictTableFull    = 3'd2;
  localparam logic [2:0] VerdictRateLimited  = 3'd3;
  localparam logic [2:0] VerdictInconsistent = 3'd4;

  typedef struct packed {
    logic load_in;
    logic check;
    logic clr_idx;
    logic inc_idx;
    logic scan_cmp;
    logic take;
    logic rd_slot;
    logic ent_ld;
    logic age;
    logic mul;
    logic sum;
    logic charge;
    logic frag;
    logic prune_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hdr_bad;
    logic idx_last;
    logic found;
    logic free_found;
    logic rate_bad;
    logic frag_bad;
    logic out_busy;
  } status_t;

endpackage

// ===== design/fap_datapath.sv =====
// fap_datapath: configuration registers, sender table memory, bucket
// arithmetic, fragment checks and the result register; uses fap_pkg
module fap_datapath #(
  parameter int SENDERS = fap_pkg::DefSenders
) (
  input  logic             clk,
  input  logic             rst,
  input  fap_pkg::cmd_t    cmd,
  output fap_pkg::status_t status,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic [15:0]      sender,
  input  logic [15:0]      packet_size,
  input  logic [7:0]       channel,
  input  logic [31:0]      now,
  input  logic [31:0]      magic_word,
  input  logic [7:0]       version_byte,
  input  logic [7:0]       channel_tag,
  input  logic [31:0]      total_bytes,
  input  logic [7:0]       part_index,
  input  logic [7:0]       part_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       verdict,
  output logic [3:0]       sender_slot
);
  import fap_pkg::*;

  localparam int SlotW = (SENDERS > 1) ? $clog2(SENDERS) : 1;

  typedef struct packed {
    logic [15:0] snd;
    logic [31:0] last;
    logic [17:0] credit;
    logic [10:0] quart;
  } entry_t;

  logic [12:0] byte_refill;
  logic [17:0] byte_burst;
  logic [10:0] pkt_burst;
  logic [31:0] idle_timeout;
  logic [15:0] elapsed_clamp;

  logic [15:0] r_sender, r_size;
  logic [7:0]  r_channel, r_version, r_tag, r_part, r_count;
  logic [31:0] r_now, r_magic, r_total;

  entry_t            ent_mem [SENDERS];
  entry_t            rd_data;
  logic [SlotW-1:0]  rd_addr;
  logic [SENDERS-1:0] valid;

  logic [SlotW-1:0] idx, slot, free_slot;
  logic             found, free_found;
  logic [31:0]      w_last;
  logic [17:0]      w_credit;
  logic [10:0]      w_quart;
  logic [15:0]      elapsed;
  logic [28:0]      prod;
  logic [16:0]      q_sum;
  logic             rate_bad, frag_bad;
  logic [2:0]       verdict_r;
  logic             has_slot;

  logic [31:0]      diff, age_now;
  logic [31:0]      prune_diff;
  logic [29:0]      c_sum;
  logic [17:0]      c_sat;
  logic [10:0]      q_sat;
  logic [MsgW-1:0]  t, need, payload, part_off, size_pl;
  logic [SlotW+3:0] slot_ext;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_refill   <= 13'd128;
      byte_burst    <= 18'd196608;
      pkt_burst     <= 11'd1024;
      idle_timeout  <= 32'd61440;
      elapsed_clamp <= 16'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegByteRefill:   byte_refill   <= cfg_data[12:0];
        RegByteBurst:    byte_burst    <= cfg_data[17:0];
        RegPktBurst:     pkt_burst     <= cfg_data[10:0];
        RegIdleTimeout:  idle_timeout  <= cfg_data;
        RegElapsedClamp: elapsed_clamp <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_sender  <= sender;
      r_size    <= packet_size;
      r_channel <= channel;
      r_now     <= now;
      r_magic   <= magic_word;
      r_version <= version_byte;
      r_tag     <= channel_tag;
      r_total   <= total_bytes;
      r_part    <= part_index;
      r_count   <= part_count;
    end
  end

  assign status.hdr_bad = (r_size <= 16'(HeaderBytes)) ||
                          (r_size > 16'(HeaderBytes + FragBytes)) ||
                          (r_channel > 8'd1) || (r_magic != FrameMagic) ||
                          (r_version != FrameVersion) || (r_tag != r_channel);

  // sender table
  assign rd_addr = cmd.rd_slot ? slot : idx;

  function automatic logic rate_bad_next();
    return (w_credit < {2'b0, r_size}) || (w_quart < QuartersPerPacket);
  endfunction

  always_ff @(posedge clk) begin
    rd_data <= ent_mem[rd_addr];
    if (cmd.charge) begin
      ent_mem[slot] <= '{snd: r_sender, last: r_now,
                         credit: (rate_bad_next() ? w_credit : w_credit - {2'b0, r_size}),
                         quart: (rate_bad_next() ? w_quart : w_quart - QuartersPerPacket)};
    end
  end

  assign prune_diff = r_now - rd_data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.take && !found && free_found) valid[free_slot] <= 1'b1;
      if (cmd.prune_cmp && valid[idx] && !prune_diff[31] && (prune_diff > idle_timeout))
        valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_idx) idx <= '0;
    else if (cmd.inc_idx) idx <= idx + SlotW'(1);
  end

  assign status.idx_last = (idx == SlotW'(SENDERS - 1));

  always_ff @(posedge clk) begin
    if (cmd.clr_idx && cmd.check) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan_cmp) begin
      if (valid[idx] && !found && (rd_data.snd == r_sender)) begin
        found <= 1'b1;
        slot  <= idx;
      end
      if (!valid[idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
    end else if (cmd.take && !found) begin
      slot <= free_slot;
    end
  end

  assign status.found      = found;
  assign status.free_found = free_found;

  // bucket arithmetic
  assign diff    = r_now - w_last;
  assign age_now = diff[31] ? 32'd0 : diff;
  assign c_sum   = {12'd0, w_credit} + {1'b0, prod};
  assign c_sat   = (c_sum > {12'd0, byte_burst}) ? byte_burst : c_sum[17:0];
  assign q_sat   = (q_sum > {6'd0, pkt_burst}) ? pkt_burst : q_sum[10:0];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      w_last   <= r_now;
      w_credit <= byte_burst;
      w_quart  <= pkt_burst;
    end else if (cmd.ent_ld) begin
      w_last   <= rd_data.last;
      w_credit <= rd_data.credit;
      w_quart  <= rd_data.quart;
    end else if (cmd.sum) begin
      w_credit <= c_sat;
      w_quart  <= q_sat;
    end
    if (cmd.age)
      elapsed <= (age_now > {16'd0, elapsed_clamp}) ? elapsed_clamp : age_now[15:0];
    if (cmd.mul) begin
      prod  <= elapsed * byte_refill;
      q_sum <= {6'd0, w_quart} + {1'b0, elapsed};
    end
    if (cmd.charge) rate_bad <= rate_bad_next();
  end

  assign status.rate_bad = rate_bad;

  // fragment consistency
  assign t        = r_total[MsgW-1:0];
  assign need     = (t + MsgW'(FragBytes - 1)) >> FragShift;
  assign part_off = MsgW'({r_part, {FragShift{1'b0}}});
  assign payload  = ((t - part_off) > MsgW'(FragBytes)) ? MsgW'(FragBytes) : (t - part_off);
  assign size_pl  = MsgW'(r_size - 16'(HeaderBytes));

  always_ff @(posedge clk) begin
    if (cmd.frag) begin
      frag_bad <= (r_total == 32'd0) || (r_total > 32'(MaxMsgBytes)) ||
                  (need != MsgW'(r_count)) || (r_part >= r_count) ||
                  (size_pl != payload);
    end
  end

  assign status.frag_bad = frag_bad;

  // verdict selection
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      verdict_r <= VerdictMalformed;
      has_slot  <= 1'b0;
    end else if (cmd.take) begin
      verdict_r <= VerdictTableFull;
      has_slot  <= found || free_found;
    end else if (cmd.charge) begin
      verdict_r <= rate_bad_next() ? VerdictRateLimited : VerdictInconsistent;
    end else if (cmd.frag) begin
      verdict_r <= VerdictInconsistent;
    end else if (cmd.prune_cmp) begin
      verdict_r <= VerdictAccept;
    end
  end

  // result register
  assign slot_ext = {4'd0, slot};
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      verdict     <= verdict_r;
      sender_slot <= has_slot ? slot_ext[3:0] : 4'd0;
    end
  end

endmodule

// ===== design/fap_ctrl.sv =====
// fap_ctrl: sequencing state machine for the policer datapath
// uses fap_pkg command and status types
module fap_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  fap_pkg::status_t status,
  output fap_pkg::cmd_t    cmd
);
  import fap_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_CHECK     = 14'b00000000000010,
    S_SCAN_RD   = 14'b00000000000100,
    S_SCAN_CMP  = 14'b00000000001000,
    S_TAKE      = 14'b00000000010000,
    S_ENT_RD    = 14'b00000000100000,
    S_ENT_LD    = 14'b00000001000000,
    S_AGE       = 14'b00000010000000,
    S_MUL       = 14'b00000100000000,
    S_SUM       = 14'b00001000000000,
    S_CHARGE    = 14'b00010000000000,
    S_FRAG      = 14'b00100000000000,
    S_PRUNE_RD  = 14'b01000000000000,
    S_PRUNE_CMP = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   done;
  logic   cmd_phase;

  assign in_stall = (state != S_IDLE) || done;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // done marks a finished verdict waiting for the result register
  logic done_next;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= done_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = done;
    unique case (state)
      S_IDLE: begin
        if (done) begin
          if (!status.out_busy) begin
            cmd.out_load = 1'b1;
            done_next    = 1'b0;
          end
        end else if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check   = 1'b1;
        cmd.clr_idx = 1'b1;
        if (status.hdr_bad) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (status.idx_last) begin
          state_next = S_TAKE;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_TAKE: begin
        cmd.take = 1'b1;
        if (status.found) begin
          state_next = S_ENT_RD;
        end else if (status.free_found) begin
          state_next = S_AGE;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ENT_RD: begin
        cmd.rd_slot = 1'b1;
        state_next  = S_ENT_LD;
      end
      S_ENT_LD: begin
        cmd.ent_ld = 1'b1;
        state_next = S_AGE;
      end
      S_AGE: begin
        cmd.age    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CHARGE;
      end
      S_CHARGE: begin
        cmd.charge = 1'b1;
        state_next = S_FRAG;
      end
      S_FRAG: begin
        if (status.rate_bad) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.frag   = 1'b1;
          state_next = S_PRUNE_RD;
        end
      end
      S_PRUNE_RD: begin
        // frag_bad is valid from here on
        if (status.frag_bad) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.clr_idx = 1'b1;
          state_next  = S_PRUNE_CMP;
        end
      end
      S_PRUNE_CMP: begin
        // idx was cleared; the registered read of entry idx lands in the following cycle
        state_next = S_PRUNE_CMP;
        if (cmd_phase) begin
          cmd.prune_cmp = 1'b1;
          if (status.idx_last) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // prune alternates read and compare cycles
  always_ff @(posedge clk) begin
    if (rst || state != S_PRUNE_CMP) cmd_phase <= 1'b0;
    else                             cmd_phase <= !cmd_phase;
  end

endmodule

// ===== design/fragment_admission_policer_top.sv =====
// fragment admission policer: header checks, sender table, dual token bucket,
// fragment checks and idle prune, in that order; a verdict is loaded once the
// first failing step is found (malformed, table full, rate limited, inconsistent),
// or after the sequential scan and idle prune when accepted
// one item at a time: the next is accepted the cycle after its result is loaded,
// later while the output register is held; reset clears valid bits and config
module fragment_admission_policer_top #(
  parameter int SENDERS = fap_pkg::DefSenders
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] sender,
  input  logic [15:0] packet_size,
  input  logic [7:0]  channel,
  input  logic [31:0] now,
  input  logic [31:0] magic_word,
  input  logic [7:0]  version_byte,
  input  logic [7:0]  channel_tag,
  input  logic [31:0] total_bytes,
  input  logic [7:0]  part_index,
  input  logic [7:0]  part_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic [3:0]  sender_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fap_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  fap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fap_datapath #(.SENDERS(SENDERS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sender       (sender),
    .packet_size  (packet_size),
    .channel      (channel),
    .now          (now),
    .magic_word   (magic_word),
    .version_byte (version_byte),
    .channel_tag  (channel_tag),
    .total_bytes  (total_bytes),
    .part_index   (part_index),
    .part_count   (part_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .sender_slot  (sender_slot)
  );

endmodule

// ===== sim/fap_checker.sv =====
`timescale 1ns / 1ps
// fap_checker: watches the fragment, result and register channels of the policer,
// predicts each verdict and slot and compares them; uses fap_pkg
module fap_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] sender,
  input  logic [15:0] packet_size,
  input  logic [7:0]  channel,
  input  logic [31:0] now,
  input  logic [31:0] magic_word,
  input  logic [7:0]  version_byte,
  input  logic [7:0]  channel_tag,
  input  logic [31:0] total_bytes,
  input  logic [7:0]  part_index,
  input  logic [7:0]  part_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  verdict,
  input  logic [3:0]  sender_slot,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import fap_pkg::*;

  localparam int Slots = DefSenders;

  typedef struct packed {
    logic [2:0] verdict;
    logic [3:0] slot;
  } admission_t;

  admission_t verdict_q[$];

  logic [12:0] refill_per_tick;
  logic [17:0] byte_cap;
  logic [10:0] quarter_cap;
  logic [31:0] idle_limit;
  logic [15:0] elapsed_cap;

  logic        slot_live[Slots];
  logic [15:0] slot_sender[Slots];
  logic [31:0] slot_tick[Slots];
  logic [17:0] slot_bytes[Slots];
  logic [10:0] slot_quarters[Slots];

  function automatic logic [31:0] idle_age(logic [31:0] t, logic [31:0] last);
    logic [31:0] d;
    d = t - last;
    return d[31] ? 32'd0 : d;
  endfunction

  task automatic police(output admission_t r);
    int hit, free_idx, used;
    logic [31:0] elapsed;
    longint unsigned credit, quarters, need, payload, total, part, count;
    hit = -1;
    free_idx = -1;
    used = 0;
    total = total_bytes;
    part = part_index;
    count = part_count;
    r = '{verdict: VerdictMalformed, slot: 4'd0};
    if (packet_size <= HeaderBytes || packet_size > HeaderBytes + FragBytes ||
        channel > 8'd1 || magic_word != FrameMagic || version_byte != FrameVersion ||
        channel_tag != channel)
      return;
    for (int i = 0; i < Slots; i++) begin
      if (slot_live[i]) begin
        used++;
        if (hit < 0 && slot_sender[i] == sender) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit < 0) begin
      if (used >= Slots || free_idx < 0) begin
        r.verdict = VerdictTableFull;
        return;
      end
      hit = free_idx;
      slot_live[hit] = 1'b1;
      slot_sender[hit] = sender;
      slot_tick[hit] = now;
      slot_bytes[hit] = byte_cap;
      slot_quarters[hit] = quarter_cap;
    end
    r.slot = hit[3:0];
    elapsed = idle_age(now, slot_tick[hit]);
    if (elapsed > elapsed_cap) elapsed = elapsed_cap;
    slot_tick[hit] = now;
    credit = longint'(slot_bytes[hit]) + longint'(elapsed) * refill_per_tick;
    if (credit > byte_cap) credit = byte_cap;
    quarters = longint'(slot_quarters[hit]) + longint'(elapsed);
    if (quarters > quarter_cap) quarters = quarter_cap;
    slot_bytes[hit] = credit[17:0];
    slot_quarters[hit] = quarters[10:0];
    if (credit < packet_size || quarters < QuartersPerPacket) begin
      r.verdict = VerdictRateLimited;
      return;
    end
    slot_bytes[hit] = credit[17:0] - packet_size;
    slot_quarters[hit] = quarters[10:0] - QuartersPerPacket;
    r.verdict = VerdictInconsistent;
    if (total == 0 || total > MaxMsgBytes) return;
    need = (total + FragBytes - 1) / FragBytes;
    if (count != need || part >= count) return;
    payload = total - part * FragBytes;
    if (payload > FragBytes) payload = FragBytes;
    if (longint'(packet_size) - HeaderBytes != payload) return;
    for (int i = 0; i < Slots; i++)
      if (slot_live[i] && idle_age(now, slot_tick[i]) > idle_limit) slot_live[i] = 1'b0;
    r.verdict = VerdictAccept;
  endtask

  assign pending = verdict_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    admission_t want, got;
    if (rst) begin
      refill_per_tick = 13'd128;
      byte_cap = 18'd196608;
      quarter_cap = 11'd1024;
      idle_limit = 32'd61440;
      elapsed_cap = 16'd2048;
      for (int i = 0; i < Slots; i++) slot_live[i] = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegByteRefill: refill_per_tick = cfg_data[12:0];
          RegByteBurst: byte_cap = cfg_data[17:0];
          RegPktBurst: quarter_cap = cfg_data[10:0];
          RegIdleTimeout: idle_limit = cfg_data;
          RegElapsedClamp: elapsed_cap = cfg_data[15:0];
          default: ;
        endcase
      end
      // results leave before the next fragment is judged
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("result transaction with nothing expected: verdict %0d slot %0d",
                 verdict, sender_slot);
          errors = errors + 1;
        end else begin
          want = verdict_q.pop_front();
          if (verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict);
            errors = errors + 1;
          end
          if (sender_slot !== want.slot) begin
            $error("sender_slot: expected %0d, got %0d", want.slot, sender_slot);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        police(got);
        verdict_q.push_back(got);
      end
    end
  end
endmodule

// ===== sim/fragment_admission_policer_top_test.sv =====
`timescale 1ns / 1ps
// fragment_admission_policer_top_test: clock, reset, fragment and register stimulus
// and the verdict; depends on fap_pkg, fap_checker and the policer top level
module fragment_admission_policer_top_test;
  import fap_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [15:0] sender, packet_size;
  logic [7:0]  channel, version_byte, channel_tag, part_index, part_count;
  logic [31:0] now, magic_word, total_bytes;
  logic        out_valid, out_stall;
  logic [2:0]  verdict;
  logic [3:0]  sender_slot;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending;

  logic        quiet;
  logic        hold_req;
  logic [31:0] ticks;

  fragment_admission_policer_top DUT (.*);

  fap_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[fragment_admission_policer_top] ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    static int hold_left = 0;
    static bit hold_done = 0;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && $urandom_range(0, 99) < 21;
    end
  end

  task automatic offer(input logic [15:0] snd, input logic [15:0] size,
                       input logic [7:0] chn, input logic [31:0] t,
                       input logic [31:0] magic, input logic [7:0] ver,
                       input logic [7:0] tag, input logic [31:0] total,
                       input logic [7:0] part, input logic [7:0] count);
    if (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    sender <= snd;
    packet_size <= size;
    channel <= chn;
    now <= t;
    magic_word <= magic;
    version_byte <= ver;
    channel_tag <= tag;
    total_bytes <= total;
    part_index <= part;
    part_count <= count;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // well-formed header; size follows from the part of the declared message
  task automatic fragment(input logic [15:0] snd, input logic [31:0] t,
                          input logic [7:0] chn, input int total, input int part);
    int count, payload;
    count = (total + FragBytes - 1) / FragBytes;
    payload = total - part * FragBytes;
    if (payload > FragBytes) payload = FragBytes;
    offer(snd, 16'(payload + HeaderBytes), chn, t, FrameMagic, FrameVersion, chn,
          32'(total), 8'(part), 8'(count));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_item;
    int pick, total, part, count;
    logic [15:0] snd;
    logic [7:0]  chn;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0: ticks = ticks - $urandom_range(1, 500);
      1: ticks = ticks + $urandom_range(60000, 200000);
      2: ticks = $urandom;
      3, 4, 5: ;
      default: ticks = ticks + $urandom_range(0, 300);
    endcase
    snd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
    chn = 8'($urandom_range(0, 1));
    total = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxMsgBytes)
                                        : $urandom_range(1, 4096);
    count = (total + FragBytes - 1) / FragBytes;
    part = $urandom_range(0, count - 1);
    if (pick < 70) begin
      fragment(snd, ticks, chn, total, part);
    end else if (pick < 85) begin
      // sound header, random fragment fields
      offer(snd, 16'($urandom_range(17, HeaderBytes + FragBytes)), chn, ticks, FrameMagic,
            FrameVersion, chn, ($urandom_range(0, 1) ? 32'($urandom) : 32'(total)),
            8'($urandom_range(0, 80)), 8'($urandom_range(0, 80)));
    end else if (pick < 92) begin
      offer(16'($urandom), 16'($urandom), 8'($urandom), ticks, $urandom, 8'($urandom),
            8'($urandom), $urandom, 8'($urandom), 8'($urandom));
    end else begin
      // one header field broken (the channel case also gives a random tag)
      case ($urandom_range(0, 3))
        0: offer(snd, 16'(HeaderBytes + 1), chn, ticks,
                 FrameMagic ^ (32'd1 << $urandom_range(0, 31)), FrameVersion, chn, 1, 0, 1);
        1: offer(snd, 16'(HeaderBytes + 1), chn, ticks, FrameMagic, 8'($urandom_range(2, 255)),
                 chn, 1, 0, 1);
        2: offer(snd, 16'(HeaderBytes + 1), 8'($urandom_range(2, 255)), ticks, FrameMagic,
                 FrameVersion, 8'($urandom), 1, 0, 1);
        default: offer(snd, 16'($urandom_range(HeaderBytes + FragBytes + 1, 65535)), chn, ticks,
                       FrameMagic, FrameVersion, chn, 1, 0, 1);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sender = '0;
    packet_size = '0;
    channel = '0;
    now = '0;
    magic_word = '0;
    version_byte = '0;
    channel_tag = '0;
    total_bytes = '0;
    part_index = '0;
    part_count = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    ticks = 32'd5000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: header checks, message bounds and time going back
    fragment(16'h0000, ticks, 8'd0, 1, 0);
    fragment(16'hFFFF, ticks, 8'd1, 65536, 63);
    fragment(16'h0001, ticks, 8'd0, 3000, 1);
    offer(16'd2, 16'd16, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 1, 0, 1);
    offer(16'd2, 16'd1041, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 1, 0, 1);
    offer(16'd2, 16'd17, 8'd2, ticks, FrameMagic, FrameVersion, 8'd2, 1, 0, 1);
    offer(16'd2, 16'd17, 8'd1, ticks, FrameMagic, FrameVersion, 8'd0, 1, 0, 1);
    offer(16'd2, 16'd17, 8'd0, ticks, 32'hFFFF_FFFF, FrameVersion, 8'd0, 1, 0, 1);
    offer(16'd2, 16'd17, 8'd0, ticks, FrameMagic, 8'd0, 8'd0, 1, 0, 1);
    offer(16'd2, 16'd17, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 0, 0, 1);
    offer(16'd2, 16'd1040, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 65537, 0, 65);
    offer(16'd2, 16'd1040, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 32'hFFFF_FFFF, 0, 255);
    offer(16'd2, 16'd1040, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 2048, 2, 2);
    offer(16'd2, 16'd1040, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 2048, 0, 3);
    offer(16'd2, 16'd100, 8'd0, ticks, FrameMagic, FrameVersion, 8'd0, 2048, 1, 2);
    fragment(16'h0001, ticks - 100, 8'd1, 1024, 0);
    fragment(16'h0001, ticks + 3000, 8'd1, 1024, 0);
    fragment(16'h0000, ticks + 70000, 8'd0, 500, 0);
    ticks = ticks + 70000;

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        1: begin
          write_reg(RegByteRefill, 32'd0);
          write_reg(RegByteBurst, 32'd0);
          write_reg(RegPktBurst, 32'd4);
          write_reg(RegIdleTimeout, 32'd0);
          write_reg(RegElapsedClamp, 32'd0);
          write_reg(3'd7, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(RegByteRefill, 32'd4096);
          write_reg(RegByteBurst, 32'd262143);
          write_reg(RegPktBurst, 32'd2047);
          write_reg(RegIdleTimeout, 32'hFFFF_FFFF);
          write_reg(RegElapsedClamp, 32'd65535);
        end
        3: begin
          write_reg(RegByteRefill, 32'd1);
          write_reg(RegByteBurst, 32'd3000);
          write_reg(RegPktBurst, 32'd12);
          write_reg(RegIdleTimeout, 32'd2000);
          write_reg(RegElapsedClamp, 32'd16);
        end
        4: begin
          write_reg(RegByteRefill, 32'd128);
          write_reg(RegByteBurst, 32'd196608);
          write_reg(RegPktBurst, 32'd1024);
          write_reg(RegIdleTimeout, 32'h8000_0000);
          write_reg(RegElapsedClamp, 32'd2048);
        end
        5: begin
          write_reg(RegByteRefill, 32'd200);
          write_reg(RegByteBurst, 32'd20000);
          write_reg(RegPktBurst, 32'd40);
          write_reg(RegIdleTimeout, 32'd61440);
          write_reg(RegElapsedClamp, 32'd300);
        end
        default: ;
      endcase
      for (int n = 0; n < 270; n++) begin
        if (phase == 2 && n == 100) hold_req <= 1'b1;
        if (phase == 3) quiet <= (n < 150);
        random_item();
      end
    end
    quiet <= 1'b0;
    drain();
    if (errors == 0)
      $display("[fragment_admission_policer_top] OK");
    else
      $display("[fragment_admission_policer_top] ERROR");
    $finish;
  end
endmodule
